@@ sv/modular_multiply_double_add_defines.svh @@
// assertion macros for the modular multiply block
`ifndef MODULAR_MULTIPLY_DOUBLE_ADD_DEFINES_SVH
`define MODULAR_MULTIPLY_DOUBLE_ADD_DEFINES_SVH

// check that a property holds on every clock edge out of reset
`define MMDA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check a property with no reset qualification
`define MMDA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/mmda_pkg.sv @@
// package with the shared field width and type of the modular multiply block
`timescale 1ns / 1ps
`default_nettype none
package mmda_pkg;
    localparam int unsigned FIELD_WIDTH = 63;
    typedef logic [FIELD_WIDTH-1:0] t_field;
endpackage
`default_nettype wire

@@ sv/mmda_if.sv @@
// valid/ready channel interfaces for operands and results
`timescale 1ns / 1ps
`default_nettype none
interface mmda_in_if;
    import mmda_pkg::*;
    logic   valid;
    logic   ready;
    t_field multiplicand;
    t_field multiplier;
    t_field modulus;
    modport source (output valid, output multiplicand, output multiplier, output modulus,
                    input ready);
    modport sink (input valid, input multiplicand, input multiplier, input modulus,
                  output ready);
endinterface

interface mmda_out_if;
    import mmda_pkg::*;
    logic   valid;
    logic   ready;
    t_field product_mod;
    logic   bad_modulus;
    modport source (output valid, output product_mod, output bad_modulus, input ready);
    modport sink (input valid, input product_mod, input bad_modulus, output ready);
endinterface
`default_nettype wire

@@ sv/modular_multiply_double_add.sv @@
// Modular multiply (a*b) mod m by double-and-add, fully pipelined. Operands are
// OPERAND_WIDTH bits (higher bits of the 63-bit fields are ignored). An input
// register captures each transaction, the multiplicand is then reduced by
// restoring shift-subtract, one quotient bit per stage (OPERAND_WIDTH stages),
// and OPERAND_WIDTH double-and-add stages each consume one multiplier bit; the
// last of them holds the result.
// One transaction can enter every cycle, and the whole pipe stalls as a unit
// when the output is not taken. A zero modulus returns 0 with bad_modulus set.
`timescale 1ns / 1ps
`default_nettype none
`include "modular_multiply_double_add_defines.svh"
module modular_multiply_double_add #(
    parameter int unsigned OPERAND_WIDTH = 63
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mmda_in_if.sink    i_in,
    mmda_out_if.source o_out
);
    import mmda_pkg::*;

    localparam int unsigned W = OPERAND_WIDTH;
    localparam int unsigned NS = 2 * W;

    // per-stage pipeline registers
    logic         r_vld  [NS+1];
    logic [W-1:0] r_rem  [NS+1];  // remainder / doubled value
    logic [W-1:0] r_num  [NS+1];  // dividend bits still to shift in
    logic [W-1:0] r_mul  [NS+1];
    logic [W-1:0] r_mod  [NS+1];
    logic [W-1:0] r_acc  [NS+1];

    logic w_adv;
    assign w_adv = !r_vld[NS] || o_out.ready;
    assign i_in.ready = w_adv;

    // stage 0 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_in.valid;
        end
        if (w_adv) begin
            r_rem[0] <= '0;
            r_num[0] <= i_in.multiplicand[W-1:0];
            r_mul[0] <= i_in.multiplier[W-1:0];
            r_mod[0] <= i_in.modulus[W-1:0];
            r_acc[0] <= '0;
        end
    end

    // reduction stages then double-and-add stages
    for (genvar s = 1; s <= NS; s++) begin : g_stage
        logic [W:0]   n_t;
        logic [W:0]   n_s;
        logic [W-1:0] n_rem;
        logic [W-1:0] n_num;
        logic [W-1:0] n_acc;
        if (s <= W) begin : g_red
            always_comb begin
                n_t   = {r_rem[s-1], r_num[s-1][W-1]};
                n_s   = n_t - {1'b0, r_mod[s-1]};
                n_rem = n_s[W] ? n_t[W-1:0] : n_s[W-1:0];
                n_num = {r_num[s-1][W-2:0], 1'b0};
                n_acc = r_acc[s-1];
            end
        end else begin : g_dbl
            logic [W:0] n_a;
            logic [W:0] n_as;
            always_comb begin
                n_a   = {1'b0, r_acc[s-1]} + {1'b0, r_rem[s-1]};
                n_as  = n_a - {1'b0, r_mod[s-1]};
                n_acc = !r_mul[s-1][s-1-W] ? r_acc[s-1] :
                        (n_as[W] ? n_a[W-1:0] : n_as[W-1:0]);
                n_t   = {r_rem[s-1], 1'b0};
                n_s   = n_t - {1'b0, r_mod[s-1]};
                n_rem = n_s[W] ? n_t[W-1:0] : n_s[W-1:0];
                n_num = r_num[s-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_adv) begin
                r_vld[s] <= r_vld[s-1];
            end
            if (w_adv) begin
                r_rem[s] <= n_rem;
                r_num[s] <= n_num;
                r_mul[s] <= r_mul[s-1];
                r_mod[s] <= r_mod[s-1];
                r_acc[s] <= n_acc;
            end
        end
    end

    // result drive; a zero modulus forces the product to 0
    logic w_bad;
    assign w_bad = (r_mod[NS] == '0);
    assign o_out.valid = r_vld[NS];
    assign o_out.product_mod = FIELD_WIDTH'(w_bad ? '0 : r_acc[NS]);
    assign o_out.bad_modulus = w_bad;

    `MMDA_ASSERT(a_res_below_mod, i_clk, i_rst_n,
        o_out.valid && !o_out.bad_modulus |-> r_acc[NS] < r_mod[NS],
        "result not reduced")
    `MMDA_ASSERT(a_stall_hold, i_clk, i_rst_n,
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.product_mod),
        "result changed while stalled")
    `MMDA_ASSERT(a_ready_when_empty, i_clk, i_rst_n,
        !o_out.valid |-> i_in.ready, "pipe blocked while output empty")
    `MMDA_ASSERT(a_red_below_mod, i_clk, i_rst_n,
        r_vld[W] && r_mod[W] != '0 |-> r_rem[W] < r_mod[W],
        "reduced multiplicand out of range")
endmodule
`default_nettype wire
